>>> hdl/stmm_pkg.sv
// Package for the sparse-table range min/max engine: sizes, status codes and shared types.
`timescale 1ns / 1ps

package stmm_pkg;

    localparam int STMM_CAPACITY = 512;
    localparam int STMM_LEVELS   = 10;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 9;
    localparam int STATUS_W      = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_QRES
    } state_t;

    // Strobes from the engine to both table memories.
    typedef struct packed {
        logic we;
        logic re_a;
        logic re_b;
    } mem_en_t;

endpackage

>>> hdl/stmm_ram.sv
// Generic RAM: one write port and two registered read ports.
`timescale 1ns / 1ps

module stmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> hdl/stmm_engine.sv
// Sequencer and datapath: table build on load, two-block lookup on query, result register.
`timescale 1ns / 1ps

module stmm_engine
    import stmm_pkg::*;
#(
    parameter int CAPACITY = STMM_CAPACITY,
    parameter int LEVELS   = STMM_LEVELS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_cmd,
    input  logic                                 in_start,
    input  logic signed [DATA_W-1:0]             in_value,
    input  logic [IDX_W-1:0]                     in_left,
    input  logic [IDX_W-1:0]                     in_right,
    output mem_en_t                              mem_en,
    output logic [$clog2(LEVELS*CAPACITY)-1:0]   waddr,
    output logic [$clog2(LEVELS*CAPACITY)-1:0]   raddr_a,
    output logic [$clog2(LEVELS*CAPACITY)-1:0]   raddr_b,
    output logic signed [DATA_W-1:0]             wdata_min,
    output logic signed [DATA_W-1:0]             wdata_max,
    input  logic signed [DATA_W-1:0]             rd_min_a,
    input  logic signed [DATA_W-1:0]             rd_max_a,
    input  logic signed [DATA_W-1:0]             rd_min_b,
    input  logic signed [DATA_W-1:0]             rd_max_b,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [DATA_W-1:0]             out_min,
    output logic signed [DATA_W-1:0]             out_max,
    output logic [STATUS_W-1:0]                  out_status
);

    localparam int AW  = $clog2(LEVELS*CAPACITY);
    localparam int CW  = $clog2(CAPACITY+1);
    localparam int IW  = $clog2(CAPACITY);
    localparam int LW  = $clog2(LEVELS);
    localparam int XW0 = (CW > IDX_W) ? CW : IDX_W;
    localparam int XW  = ((XW0 > LEVELS) ? XW0 : LEVELS) + 1;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            pos_reg, pos_next;
    logic [LW-1:0]            level_reg, level_next;
    logic signed [DATA_W-1:0] acc_min_reg, acc_min_next;
    logic signed [DATA_W-1:0] acc_max_reg, acc_max_next;
    logic [STATUS_W-1:0]      qstat_reg, qstat_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_min_reg, m_min_next;
    logic signed [DATA_W-1:0] m_max_reg, m_max_next;
    logic [STATUS_W-1:0]      m_status_reg, m_status_next;

    logic                     accept;
    logic                     out_free;
    logic [CW-1:0]            load_pos;
    logic                     load_ok;
    logic [XW-1:0]            in_pos1;
    logic [XW-1:0]            q_l, q_r, q_len, q_b;
    logic [LW-1:0]            q_k;
    logic [STATUS_W-1:0]      q_stat;
    logic [XW-1:0]            pos1;
    logic [XW-1:0]            cur_len, nxt_len;
    logic [XW-1:0]            cur_idx, nxt_idx;
    logic                     nxt_ok;
    logic signed [DATA_W-1:0] new_min, new_max;
    logic signed [DATA_W-1:0] res_min, res_max;

    function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lv,
                                                 input logic [IW-1:0] ix);
        return AW'(lv) * AW'(CAPACITY) + AW'(ix);
    endfunction

    function automatic logic signed [DATA_W-1:0] s_min(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic signed [DATA_W-1:0] s_max(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    assign accept   = in_valid && in_ready;
    assign out_free = !m_valid_reg || out_ready;

    // Load side: where the new element lands once a start mark has cleared the count.
    assign load_pos = in_start ? '0 : count_reg;
    assign load_ok  = load_pos < CW'(CAPACITY);
    assign in_pos1  = XW'(load_pos) + XW'(1);

    // Query side: block length is the largest power of two within the range length.
    assign q_l   = XW'(in_left);
    assign q_r   = XW'(in_right);
    assign q_len = q_r - q_l + XW'(1);

    always_comb begin
        q_k = '0;
        for (int i = 1; i < LEVELS; i++) begin
            if ((XW'(1) << i) <= q_len) begin
                q_k = LW'(i);
            end
        end
    end

    assign q_b = q_r + XW'(1) - (XW'(1) << q_k);

    always_comb begin
        if (q_l > q_r) begin
            q_stat = STATUS_EMPTY;
        end else if (q_r >= XW'(count_reg)) begin
            q_stat = STATUS_BEYOND;
        end else begin
            q_stat = STATUS_OK;
        end
    end

    // Level j combines the entry just read with the running result of level j-1,
    // which is the block that ends at the new element.
    assign pos1    = XW'(pos_reg) + XW'(1);
    assign cur_len = XW'(1) << level_reg;
    assign nxt_len = cur_len << 1;
    assign cur_idx = pos1 - cur_len;
    assign nxt_idx = pos1 - nxt_len;
    assign nxt_ok  = (level_reg != LW'(LEVELS-1)) && (nxt_len <= pos1);
    assign new_min = s_min(rd_min_a, acc_min_reg);
    assign new_max = s_max(rd_max_a, acc_max_reg);
    assign res_min = s_min(rd_min_a, rd_min_b);
    assign res_max = s_max(rd_max_a, rd_max_b);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_QUERY) begin
                        state_next = ST_QRES;
                    end else if (load_ok && (in_pos1 >= XW'(2))) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                if (!nxt_ok) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRES: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs to the memories and the register next values.
    always_comb begin
        in_ready      = 1'b0;
        mem_en        = '0;
        waddr         = slot_addr('0, IW'(load_pos));
        raddr_a       = slot_addr('0, IW'(load_pos - CW'(1)));
        raddr_b       = slot_addr(q_k, IW'(q_b));
        wdata_min     = in_value;
        wdata_max     = in_value;
        count_next    = count_reg;
        pos_next      = pos_reg;
        level_next    = level_reg;
        acc_min_next  = acc_min_reg;
        acc_max_next  = acc_max_reg;
        qstat_next    = qstat_reg;
        m_valid_next  = m_valid_reg && !out_ready;
        m_min_next    = m_min_reg;
        m_max_next    = m_max_reg;
        m_status_next = m_status_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    if (in_cmd == CMD_QUERY) begin
                        qstat_next = q_stat;
                        raddr_a    = slot_addr(q_k, IW'(q_l));
                        if (q_stat == STATUS_OK) begin
                            mem_en.re_a = 1'b1;
                            mem_en.re_b = 1'b1;
                        end
                    end else if (load_ok) begin
                        mem_en.we    = 1'b1;
                        mem_en.re_a  = in_pos1 >= XW'(2);
                        count_next   = load_pos + CW'(1);
                        pos_next     = load_pos;
                        level_next   = LW'(1);
                        acc_min_next = in_value;
                        acc_max_next = in_value;
                    end else begin
                        // Full array: the word is dropped.
                        count_next = load_pos;
                    end
                end
            end
            ST_LOAD: begin
                mem_en.we    = 1'b1;
                mem_en.re_a  = nxt_ok;
                waddr        = slot_addr(level_reg, IW'(cur_idx));
                raddr_a      = slot_addr(level_reg, IW'(nxt_idx));
                wdata_min    = new_min;
                wdata_max    = new_max;
                acc_min_next = new_min;
                acc_max_next = new_max;
                level_next   = level_reg + LW'(1);
            end
            ST_QRES: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = qstat_reg;
                    m_min_next    = (qstat_reg == STATUS_OK) ? res_min : '0;
                    m_max_next    = (qstat_reg == STATUS_OK) ? res_max : '0;
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        level_reg    <= level_next;
        acc_min_reg  <= acc_min_next;
        acc_max_reg  <= acc_max_next;
        qstat_reg    <= qstat_next;
        m_min_reg    <= m_min_next;
        m_max_reg    <= m_max_next;
        m_status_reg <= m_status_next;
    end

    assign out_valid  = m_valid_reg;
    assign out_min    = m_min_reg;
    assign out_max    = m_max_reg;
    assign out_status = m_status_reg;

endmodule

>>> hdl/sparse_table_range_min_max.sv
// Load: level 0 is written as the word is taken, then the build state adds one table level a
// cycle through the single read port used for the build (one read and one write per level).
// Query: taken in idle, the result word is registered in the result state once m_ is free;
// the next word waits until the engine is back in idle; a result may still wait on m_.
// Reset (aresetn low, synchronous) clears the element count and the handshake state only;
// the table memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module sparse_table_range_min_max
    import stmm_pkg::*;
#(
    parameter int CAPACITY = STMM_CAPACITY,
    parameter int LEVELS   = STMM_LEVELS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // value[31:0], left[40:32], right[49:41], zero[55:50]
    input  logic [1:0]  s_tuser,   // cmd[0], start_req[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // range_min[31:0], range_max[63:32]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int DEPTH = LEVELS * CAPACITY;
    localparam int AW    = $clog2(DEPTH);

    mem_en_t                  mem_en;
    logic [AW-1:0]            waddr, raddr_a, raddr_b;
    logic signed [DATA_W-1:0] wdata_min, wdata_max;
    logic signed [DATA_W-1:0] rd_min_a, rd_min_b, rd_max_a, rd_max_b;
    logic signed [DATA_W-1:0] out_min, out_max;

    stmm_engine #(
        .CAPACITY (CAPACITY),
        .LEVELS   (LEVELS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser[0]),
        .in_start   (s_tuser[1]),
        .in_value   (s_tdata[31:0]),
        .in_left    (s_tdata[40:32]),
        .in_right   (s_tdata[49:41]),
        .mem_en     (mem_en),
        .waddr      (waddr),
        .raddr_a    (raddr_a),
        .raddr_b    (raddr_b),
        .wdata_min  (wdata_min),
        .wdata_max  (wdata_max),
        .rd_min_a   (rd_min_a),
        .rd_max_a   (rd_max_a),
        .rd_min_b   (rd_min_b),
        .rd_max_b   (rd_max_b),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_min    (out_min),
        .out_max    (out_max),
        .out_status (m_tuser)
    );

    stmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_min_table (
        .aclk    (aclk),
        .we      (mem_en.we),
        .waddr   (waddr),
        .wdata   (wdata_min),
        .re_a    (mem_en.re_a),
        .raddr_a (raddr_a),
        .rdata_a (rd_min_a),
        .re_b    (mem_en.re_b),
        .raddr_b (raddr_b),
        .rdata_b (rd_min_b)
    );

    stmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_max_table (
        .aclk    (aclk),
        .we      (mem_en.we),
        .waddr   (waddr),
        .wdata   (wdata_max),
        .re_a    (mem_en.re_a),
        .raddr_a (raddr_a),
        .rdata_a (rd_max_a),
        .re_b    (mem_en.re_b),
        .raddr_b (raddr_b),
        .rdata_b (rd_max_b)
    );

    assign m_tdata = {out_max, out_min};

endmodule
